/* design/vat_pkg.sv */
// vat_pkg: widths, shared types and reset values for the vertex affine transform.
// No dependencies; every other design file refers to it by scoped names.

package vat_pkg;

  // Field and arithmetic widths
  localparam int COMP_W       = 32;   // one Q16.16 component
  localparam int FRAC_BITS    = 16;   // fraction bits of Q16.16
  localparam int NUM_COMP     = 4;    // x, y, z, w
  localparam int NUM_MUL_ROWS = 3;    // rows that multiply a vertex component
  localparam int PROD_W       = 2 * COMP_W;   // exact Q32.32 product
  localparam int SUM_W        = PROD_W + 2;   // three products plus translation
  localparam int SHIFT_W      = SUM_W - FRAC_BITS;

  // Configuration port
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 4;    // one spare bit so out-of-range writes exist
  localparam int NUM_CFG_REGS = 8;

  // Saturation limits
  localparam logic [COMP_W-1:0] COMP_MAX = {1'b0, {(COMP_W-1){1'b1}}};
  localparam logic [COMP_W-1:0] COMP_MIN = {1'b1, {(COMP_W-1){1'b0}}};

  typedef logic [NUM_CFG_REGS-1:0][CFG_W-1:0] cfg_regs_t;
  // Matrix entry m[row][col], raw Q16.16 bits
  typedef logic [NUM_COMP-1:0][NUM_COMP-1:0][COMP_W-1:0] mat_t;
  typedef logic [NUM_COMP-1:0][NUM_MUL_ROWS-1:0][PROD_W-1:0] prod_arr_t;
  typedef logic [NUM_COMP-1:0][SUM_W-1:0] sum_arr_t;
  typedef logic [NUM_COMP-1:0][COMP_W-1:0] comp_arr_t;

  // Identity matrix; register 7 first in the concatenation
  localparam cfg_regs_t CFG_RESET = {
    64'h0001_0000_0000_0000,   // row 3 high: m[3][3] = 1.0
    64'h0000_0000_0000_0000,   // row 3 low
    64'h0000_0000_0001_0000,   // row 2 high: m[2][2] = 1.0
    64'h0000_0000_0000_0000,   // row 2 low
    64'h0000_0000_0000_0000,   // row 1 high
    64'h0001_0000_0000_0000,   // row 1 low: m[1][1] = 1.0
    64'h0000_0000_0000_0000,   // row 0 high
    64'h0000_0000_0001_0000    // row 0 low: m[0][0] = 1.0
  };

  // Unpack the register file into matrix entries: two entries per register,
  // even column in the low half.
  function automatic mat_t regs_to_mat(input cfg_regs_t regs);
    mat_t m;
    for (int r = 0; r < NUM_COMP; r++) begin
      for (int c = 0; c < NUM_COMP; c++) begin
        m[r][c] = regs[r*2 + c/2][(c%2)*COMP_W +: COMP_W];
      end
    end
    return m;
  endfunction

endpackage

/* design/vertex_affine_transform_top.sv */
// vertex_affine_transform_top: 4x4 matrix by point transform, signed Q16.16.
// Depends on vat_pkg, vat_mul_stage, vat_acc_stage and vat_sat_stage.
//
// Usage:
//   Input: drive in_x, in_y, in_z with start high; a transaction is taken at
//   a clock edge where start is high and busy is low. busy is high only
//   during reset and the cycle after it, so one vertex can enter every cycle.
//   Output: out_valid is high for exactly one cycle with out_x..out_w; the
//   result passes the register stages in order (multiply, two add stages,
//   shift/saturate). Sustained throughput is one vertex per cycle; the four
//   register stages set the latency, the twelve parallel multipliers set the
//   rate. The receiver cannot stall the block; every result shows once.
//   Configuration: cfg_valid/cfg_ready with cfg_index and 64-bit cfg_data
//   write matrix register cfg_index (0 to 7); higher indexes are dropped.
//   Write only while no vertex is in flight.
//   Reset: synchronous, active low; clears the pipeline valid bits and loads identity.

module vertex_affine_transform_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [vat_pkg::COMP_W-1:0] in_x,
  input  logic signed [vat_pkg::COMP_W-1:0] in_y,
  input  logic signed [vat_pkg::COMP_W-1:0] in_z,
  output logic                          out_valid,
  output logic signed [vat_pkg::COMP_W-1:0] out_x,
  output logic signed [vat_pkg::COMP_W-1:0] out_y,
  output logic signed [vat_pkg::COMP_W-1:0] out_z,
  output logic signed [vat_pkg::COMP_W-1:0] out_w,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vat_pkg::CFG_W-1:0]     cfg_data
);

  vat_pkg::cfg_regs_t  cfg_regs_r;
  vat_pkg::mat_t       mat;
  logic                busy_r;
  logic                accept;
  logic                mul_valid, acc_valid;
  vat_pkg::prod_arr_t  prod;
  vat_pkg::sum_arr_t   sum;
  vat_pkg::comp_arr_t  comp;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r;
  assign accept    = start && !busy_r;
  assign mat       = vat_pkg::regs_to_mat(cfg_regs_r);

  // Hold busy through reset and release it in the cycle after reset ends
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Matrix registers; drop writes beyond the last register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_regs_r <= vat_pkg::CFG_RESET;
    end else if (cfg_valid && cfg_ready &&
                 cfg_index < vat_pkg::CFG_IDX_W'(vat_pkg::NUM_CFG_REGS)) begin
      cfg_regs_r[cfg_index[$clog2(vat_pkg::NUM_CFG_REGS)-1:0]] <= cfg_data;
    end
  end

  vat_mul_stage u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .mat      (mat),
    .valid_r  (mul_valid),
    .prod_r   (prod)
  );

  vat_acc_stage u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (mul_valid),
    .prod     (prod),
    .mat      (mat),
    .valid_r  (acc_valid),
    .sum_r    (sum)
  );

  vat_sat_stage u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (acc_valid),
    .sum      (sum),
    .valid_r  (out_valid),
    .comp_r   (comp)
  );

  assign out_x = comp[0];
  assign out_y = comp[1];
  assign out_z = comp[2];
  assign out_w = comp[3];

  // Every accepted vertex leaves the last stage with out_valid
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_valid)
    else $error("accepted vertex produced no result");

  // No result appears without a matching accepted vertex
  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 4))
    else $error("result without an accepted vertex");

  // Once out of reset the pipeline never refuses a vertex
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

/* design/vat_mul_stage.sv */
// vat_mul_stage: first pipeline stage, twelve exact 32x32 signed products.
// Depends on vat_pkg for widths and the matrix type.

module vat_mul_stage (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [vat_pkg::COMP_W-1:0] in_x,
  input  logic [vat_pkg::COMP_W-1:0] in_y,
  input  logic [vat_pkg::COMP_W-1:0] in_z,
  input  vat_pkg::mat_t           mat,
  output logic                    valid_r,
  output vat_pkg::prod_arr_t      prod_r
);

  logic [vat_pkg::NUM_MUL_ROWS-1:0][vat_pkg::COMP_W-1:0] vin;
  vat_pkg::prod_arr_t prod_nxt;

  assign vin = {in_z, in_y, in_x};

  // Form m[r][c] * v[r] for every output column
  always_comb begin
    for (int c = 0; c < vat_pkg::NUM_COMP; c++) begin
      for (int r = 0; r < vat_pkg::NUM_MUL_ROWS; r++) begin
        prod_nxt[c][r] = vat_pkg::PROD_W'($signed(mat[r][c]) * $signed(vin[r]));
      end
    end
  end

  // Advance valid; hold products without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* design/vat_acc_stage.sv */
// vat_acc_stage: two pipeline stages that sum three products and the
// translation term at full width. Depends on vat_pkg.

module vat_acc_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  vat_pkg::prod_arr_t prod,
  input  vat_pkg::mat_t      mat,
  output logic               valid_r,
  output vat_pkg::sum_arr_t  sum_r
);

  localparam int EXT_P = vat_pkg::SUM_W - vat_pkg::PROD_W;
  localparam int EXT_T = vat_pkg::SUM_W - vat_pkg::COMP_W - vat_pkg::FRAC_BITS;

  vat_pkg::sum_arr_t half_a_nxt, half_b_nxt, half_a_r, half_b_r, sum_nxt;
  logic              half_valid_r;

  // Pair the terms: x and y products, z product and translation in Q32.32
  always_comb begin
    for (int c = 0; c < vat_pkg::NUM_COMP; c++) begin
      half_a_nxt[c] = {{EXT_P{prod[c][0][vat_pkg::PROD_W-1]}}, prod[c][0]}
                    + {{EXT_P{prod[c][1][vat_pkg::PROD_W-1]}}, prod[c][1]};
      half_b_nxt[c] = {{EXT_P{prod[c][2][vat_pkg::PROD_W-1]}}, prod[c][2]}
                    + {{EXT_T{mat[3][c][vat_pkg::COMP_W-1]}}, mat[3][c],
                       {vat_pkg::FRAC_BITS{1'b0}}};
    end
  end

  // Final sum of the two halves
  always_comb begin
    for (int c = 0; c < vat_pkg::NUM_COMP; c++) begin
      sum_nxt[c] = half_a_r[c] + half_b_r[c];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_valid_r <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      half_valid_r <= in_valid;
      valid_r      <= half_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      half_a_r <= half_a_nxt;
      half_b_r <= half_b_nxt;
    end
    if (half_valid_r) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

/* design/vat_sat_stage.sv */
// vat_sat_stage: last pipeline stage, floor shift by 16 and saturation to
// 32 bits into the output registers. Depends on vat_pkg.

module vat_sat_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  vat_pkg::sum_arr_t   sum,
  output logic                valid_r,
  output vat_pkg::comp_arr_t  comp_r
);

  localparam int TOP = vat_pkg::SUM_W - 1;
  localparam int SGN = vat_pkg::FRAC_BITS + vat_pkg::COMP_W - 1;

  vat_pkg::comp_arr_t comp_nxt;
  logic [vat_pkg::NUM_COMP-1:0][vat_pkg::SHIFT_W-1:0] shifted;

  // Drop fraction bits (floor), clamp when the upper bits are not all sign
  always_comb begin
    for (int c = 0; c < vat_pkg::NUM_COMP; c++) begin
      shifted[c] = sum[c][TOP:vat_pkg::FRAC_BITS];
      if (&sum[c][TOP:SGN] || ~|sum[c][TOP:SGN]) begin
        comp_nxt[c] = shifted[c][vat_pkg::COMP_W-1:0];
      end else if (sum[c][TOP]) begin
        comp_nxt[c] = vat_pkg::COMP_MIN;
      end else begin
        comp_nxt[c] = vat_pkg::COMP_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      comp_r <= comp_nxt;
    end
  end

endmodule
